>>> rtl/core/pac_pkg.sv
// pac_pkg: shared widths, controller states, datapath commands and status
// for the polygon area and centroid block. No dependencies.
`timescale 1ns / 1ps

package pac_pkg;

	// Coordinate grid and vertex limits
	localparam int COORD_W      = 16;
	localparam int MAX_VERTICES = 1024;
	localparam int CNT_W        = $clog2(MAX_VERTICES + 2);

	// Accumulator and product widths
	localparam int AREA_W  = 43;
	localparam int CROSS_W = 44;
	localparam int MOM_W   = 61;
	localparam int OPA_W   = COORD_W + 1;
	localparam int K_W     = 2 * COORD_W + 1;
	localparam int PROD_W  = OPA_W + K_W;
	localparam int DIVR_W  = CROSS_W + 2;
	localparam int STEP_W  = $clog2(MOM_W + 1);

	// Controller states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_A,
		ST_MUL_B,
		ST_CROSS,
		ST_MOM_X,
		ST_MOM_Y,
		ST_ACC_Y,
		ST_DIV_PREP,
		ST_DIVX_GO,
		ST_DIVX_WAIT,
		ST_DIVY_GO,
		ST_DIVY_WAIT,
		ST_RESULT
	} state_t;

	// Datapath operations
	typedef enum logic [3:0] {
		DP_NOP,
		DP_TAKE,
		DP_MUL_A,
		DP_MUL_B,
		DP_CROSS,
		DP_MOM_X,
		DP_MOM_Y,
		DP_ACC_Y,
		DP_DIV_PREP,
		DP_LATCH_QX,
		DP_LATCH_QY,
		DP_EMIT
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   edge_close;  // edge ends on the first vertex
		logic   div_start;
		logic   div_sel_y;
	} cmd_t;

	typedef struct packed {
		logic count_zero;
		logic count_full;
		logic cross_zero;
		logic div_done;
		logic out_free;
	} stat_t;

endpackage

>>> rtl/core/pac_divider.sv
// pac_divider: sequential signed divider, one quotient bit per cycle,
// truncating toward zero and saturating to the coordinate range. Uses pac_pkg.
`timescale 1ns / 1ps

module pac_divider (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic signed [pac_pkg::MOM_W-1:0]    dividend,
	input  logic signed [pac_pkg::DIVR_W-1:0]   divisor,
	output logic                                done,
	output logic signed [pac_pkg::COORD_W-1:0]  quot
);

	localparam int MW = pac_pkg::MOM_W;
	localparam int DW = pac_pkg::DIVR_W;
	localparam int CW = pac_pkg::COORD_W;
	localparam int SW = pac_pkg::STEP_W;
	localparam logic [MW-1:0] POS_LIM = {{(MW-CW+1){1'b0}}, {(CW-1){1'b1}}};
	localparam logic [MW-1:0] NEG_LIM = POS_LIM + {{(MW-1){1'b0}}, 1'b1};

	logic          busy_q;
	logic          done_q;
	logic [SW-1:0] step_q;
	logic [DW-1:0] rem_q;
	logic [MW-1:0] dvd_q;   // dividend bits out, quotient bits in
	logic [DW-1:0] dsr_q;
	logic          neg_q;
	logic [CW-1:0] quot_q;

	logic [MW-1:0] dvd_mag;
	logic [DW-1:0] dsr_mag;
	logic [DW:0]   rem_sh;
	logic [DW:0]   diff;
	logic          ge;
	logic [DW-1:0] rem_next;
	logic [CW-1:0] sat_q;

	// Operand magnitudes
	assign dvd_mag = dividend[MW-1] ? (~dividend) + {{(MW-1){1'b0}}, 1'b1} : dividend;
	assign dsr_mag = divisor[DW-1] ? (~divisor) + {{(DW-1){1'b0}}, 1'b1} : divisor;

	// Restoring step
	assign rem_sh   = {rem_q, dvd_q[MW-1]};
	assign diff     = rem_sh - {1'b0, dsr_q};
	assign ge       = rem_sh >= {1'b0, dsr_q};
	assign rem_next = ge ? diff[DW-1:0] : rem_sh[DW-1:0];

	// Sign and saturation of the finished quotient
	always_comb begin
		if (!neg_q) begin
			sat_q = (dvd_q > POS_LIM) ? {1'b0, {(CW-1){1'b1}}} : dvd_q[CW-1:0];
		end else begin
			sat_q = (dvd_q > NEG_LIM) ? {1'b1, {(CW-1){1'b0}}} :
				(~dvd_q[CW-1:0]) + {{(CW-1){1'b0}}, 1'b1};
		end
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= SW'(MW);
			end else if (busy_q) begin
				if (step_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q - {{(SW-1){1'b0}}, 1'b1};
				end
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dvd_mag;
			dsr_q <= dsr_mag;
			neg_q <= dividend[MW-1] ^ divisor[DW-1];
		end else if (busy_q) begin
			if (step_q == '0) begin
				quot_q <= sat_q;
			end else begin
				rem_q <= rem_next;
				dvd_q <= {dvd_q[MW-2:0], ge};
			end
		end
	end

	assign done = done_q;
	assign quot = quot_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q) else $error("divider started while busy");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q) else $error("divider done while still busy");
	a_finish: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && step_q == '0 && !start) |=> done_q)
		else $error("divider missed its done pulse");

endmodule

>>> rtl/core/pac_datapath.sv
// pac_datapath: vertex registers, shared multiplier, shoelace accumulators,
// divider and output register. Uses pac_pkg and pac_divider.
`timescale 1ns / 1ps

module pac_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic signed [pac_pkg::COORD_W-1:0]  vertex_x,
	input  logic signed [pac_pkg::COORD_W-1:0]  vertex_y,
	input  pac_pkg::cmd_t                       cmd,
	output pac_pkg::stat_t                      stat,
	input  logic                                out_stall,
	output logic                                out_valid,
	output logic signed [pac_pkg::AREA_W-1:0]   doubled_area,
	output logic signed [pac_pkg::COORD_W-1:0]  centroid_x,
	output logic signed [pac_pkg::COORD_W-1:0]  centroid_y,
	output logic                                degenerate,
	output logic                                overflow
);

	localparam int CW = pac_pkg::COORD_W;
	localparam int NW = pac_pkg::CNT_W;
	localparam int AW = pac_pkg::AREA_W;
	localparam int XW = pac_pkg::CROSS_W;
	localparam int MW = pac_pkg::MOM_W;
	localparam int OW = pac_pkg::OPA_W;
	localparam int KW = pac_pkg::K_W;
	localparam int PW = pac_pkg::PROD_W;
	localparam int DW = pac_pkg::DIVR_W;
	localparam logic [NW-1:0] CNT_MAX = NW'(pac_pkg::MAX_VERTICES);
	localparam logic [NW-1:0] CNT_ONE = {{(NW-1){1'b0}}, 1'b1};

	// Vertex and accumulator state
	logic signed [CW-1:0] first_x_q, first_y_q, prev_x_q, prev_y_q;
	logic signed [CW-1:0] cur_x_q, cur_y_q;
	logic signed [XW-1:0] cross_q;
	logic signed [MW-1:0] mx_q, my_q;
	logic [NW-1:0]        cnt_q;

	// Arithmetic pipeline registers
	logic signed [PW-1:0]     mul_q;
	logic signed [2*CW-1:0]   t_q;
	logic signed [KW-1:0]     k_q;
	logic signed [DW-1:0]     div_q;
	logic signed [CW-1:0]     qx_q, qy_q;

	// Output register
	logic                 out_valid_q;
	logic signed [AW-1:0] area_q;
	logic signed [CW-1:0] cent_x_q, cent_y_q;
	logic                 degen_q, ovf_q;

	logic signed [CW-1:0] px, py, cx, cy;
	logic signed [OW-1:0] op_a;
	logic signed [KW-1:0] op_b;
	logic signed [PW-1:0] prod;
	logic signed [KW-1:0] k_new;
	logic signed [DW-1:0] cross_ext;
	logic signed [MW-1:0] dvd_sel;
	logic signed [CW-1:0] quot;
	logic                 div_done;
	logic                 ovf_now;
	logic                 cross_zero;
	logic                 out_free;

	// Edge end points
	assign px = prev_x_q;
	assign py = prev_y_q;
	assign cx = cmd.edge_close ? first_x_q : cur_x_q;
	assign cy = cmd.edge_close ? first_y_q : cur_y_q;

	// Shared multiplier operand select
	always_comb begin
		op_a = '0;
		op_b = '0;
		case (cmd.op)
			pac_pkg::DP_MUL_A: begin
				op_a = {px[CW-1], px};
				op_b = {{(KW-CW){cy[CW-1]}}, cy};
			end
			pac_pkg::DP_MUL_B: begin
				op_a = {cx[CW-1], cx};
				op_b = {{(KW-CW){py[CW-1]}}, py};
			end
			pac_pkg::DP_MOM_X: begin
				op_a = {px[CW-1], px} + {cx[CW-1], cx};
				op_b = k_q;
			end
			pac_pkg::DP_MOM_Y: begin
				op_a = {py[CW-1], py} + {cy[CW-1], cy};
				op_b = k_q;
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	assign prod  = op_a * op_b;
	assign k_new = {t_q[2*CW-1], t_q} - {mul_q[2*CW-1], mul_q[2*CW-1:0]};

	assign cross_ext  = {{(DW-XW){cross_q[XW-1]}}, cross_q};
	assign dvd_sel    = cmd.div_sel_y ? my_q : mx_q;
	assign ovf_now    = cnt_q > CNT_MAX;
	assign cross_zero = cross_q == '0;
	assign out_free   = !out_valid_q || !out_stall;

	// Division of the moments by three times the cross sum
	pac_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dvd_sel),
		.divisor  (div_q),
		.done     (div_done),
		.quot     (quot)
	);

	// Polygon state: vertices, count and accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_x_q <= '0;
			first_y_q <= '0;
			prev_x_q  <= '0;
			prev_y_q  <= '0;
			cross_q   <= '0;
			mx_q      <= '0;
			my_q      <= '0;
			cnt_q     <= '0;
		end else begin
			case (cmd.op)
				pac_pkg::DP_TAKE: begin
					if (cnt_q == '0) begin
						first_x_q <= vertex_x;
						first_y_q <= vertex_y;
						prev_x_q  <= vertex_x;
						prev_y_q  <= vertex_y;
						cnt_q     <= CNT_ONE;
					end else if (cnt_q < CNT_MAX) begin
						cnt_q <= cnt_q + CNT_ONE;
					end else begin
						cnt_q <= CNT_MAX + CNT_ONE;
					end
				end
				pac_pkg::DP_CROSS: begin
					cross_q <= cross_q + {{(XW-KW){k_new[KW-1]}}, k_new};
				end
				pac_pkg::DP_MOM_Y: begin
					mx_q <= mx_q + {{(MW-PW){mul_q[PW-1]}}, mul_q};
				end
				pac_pkg::DP_ACC_Y: begin
					my_q     <= my_q + {{(MW-PW){mul_q[PW-1]}}, mul_q};
					prev_x_q <= cx;
					prev_y_q <= cy;
				end
				pac_pkg::DP_EMIT: begin
					first_x_q <= '0;
					first_y_q <= '0;
					prev_x_q  <= '0;
					prev_y_q  <= '0;
					cross_q   <= '0;
					mx_q      <= '0;
					my_q      <= '0;
					cnt_q     <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	// Arithmetic working registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			pac_pkg::DP_TAKE: begin
				cur_x_q <= vertex_x;
				cur_y_q <= vertex_y;
			end
			pac_pkg::DP_MUL_A: mul_q <= prod;
			pac_pkg::DP_MUL_B: begin
				t_q   <= mul_q[2*CW-1:0];
				mul_q <= prod;
			end
			pac_pkg::DP_CROSS:    k_q   <= k_new;
			pac_pkg::DP_MOM_X:    mul_q <= prod;
			pac_pkg::DP_MOM_Y:    mul_q <= prod;
			pac_pkg::DP_DIV_PREP: div_q <= cross_ext + {cross_ext[DW-2:0], 1'b0};
			pac_pkg::DP_LATCH_QX: qx_q  <= quot;
			pac_pkg::DP_LATCH_QY: qy_q  <= quot;
			default: begin
			end
		endcase
	end

	// Output register: valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.op == pac_pkg::DP_EMIT) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register: payload
	always_ff @(posedge clk) begin
		if (cmd.op == pac_pkg::DP_EMIT) begin
			area_q   <= ovf_now ? '0 : cross_q[AW-1:0];
			cent_x_q <= (ovf_now || cross_zero) ? '0 : qx_q;
			cent_y_q <= (ovf_now || cross_zero) ? '0 : qy_q;
			degen_q  <= !ovf_now && cross_zero;
			ovf_q    <= ovf_now;
		end
	end

	assign stat.count_zero = cnt_q == '0;
	assign stat.count_full = cnt_q >= CNT_MAX;
	assign stat.cross_zero = cross_zero;
	assign stat.div_done   = div_done;
	assign stat.out_free   = out_free;

	assign out_valid    = out_valid_q;
	assign doubled_area = area_q;
	assign centroid_x   = cent_x_q;
	assign centroid_y   = cent_y_q;
	assign degenerate   = degen_q;
	assign overflow     = ovf_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == pac_pkg::DP_EMIT) |-> out_free)
		else $error("result loaded over a pending transaction");
	a_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == pac_pkg::DP_EMIT) |=>
		(cnt_q == '0 && cross_q == '0 && mx_q == '0 && my_q == '0))
		else $error("polygon state not cleared after result");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_MAX + CNT_ONE) else $error("vertex count out of range");
	a_ovf_result: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == pac_pkg::DP_EMIT && ovf_now) |=> (ovf_q && area_q == '0 && !degen_q))
		else $error("overflow result malformed");

endmodule

>>> rtl/core/pac_ctrl.sv
// pac_ctrl: controller state machine sequencing the edge arithmetic,
// closing edge, divisions and result hand-off. Uses pac_pkg.
`timescale 1ns / 1ps

module pac_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  logic           last_vertex,
	input  pac_pkg::stat_t stat,
	output pac_pkg::cmd_t  cmd
);

	pac_pkg::state_t st_q, st_nxt;
	logic            last_q, last_nxt;
	logic            closing_q, closing_nxt;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= pac_pkg::ST_IDLE;
			last_q    <= 1'b0;
			closing_q <= 1'b0;
		end else begin
			st_q      <= st_nxt;
			last_q    <= last_nxt;
			closing_q <= closing_nxt;
		end
	end

	// Next state and commands
	always_comb begin
		st_nxt         = st_q;
		last_nxt       = last_q;
		closing_nxt    = closing_q;
		cmd.op         = pac_pkg::DP_NOP;
		cmd.edge_close = closing_q;
		cmd.div_start  = 1'b0;
		cmd.div_sel_y  = 1'b0;
		in_stall       = 1'b1;
		case (st_q)
			pac_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.op   = pac_pkg::DP_TAKE;
					last_nxt = last_vertex;
					if (stat.count_zero) begin
						// a lone vertex closes onto itself
						if (last_vertex) begin
							closing_nxt = 1'b1;
							st_nxt      = pac_pkg::ST_MUL_A;
						end
					end else if (!stat.count_full) begin
						closing_nxt = 1'b0;
						st_nxt      = pac_pkg::ST_MUL_A;
					end else if (last_vertex) begin
						st_nxt = pac_pkg::ST_RESULT;
					end
				end
			end
			pac_pkg::ST_MUL_A: begin
				cmd.op = pac_pkg::DP_MUL_A;
				st_nxt = pac_pkg::ST_MUL_B;
			end
			pac_pkg::ST_MUL_B: begin
				cmd.op = pac_pkg::DP_MUL_B;
				st_nxt = pac_pkg::ST_CROSS;
			end
			pac_pkg::ST_CROSS: begin
				cmd.op = pac_pkg::DP_CROSS;
				st_nxt = pac_pkg::ST_MOM_X;
			end
			pac_pkg::ST_MOM_X: begin
				cmd.op = pac_pkg::DP_MOM_X;
				st_nxt = pac_pkg::ST_MOM_Y;
			end
			pac_pkg::ST_MOM_Y: begin
				cmd.op = pac_pkg::DP_MOM_Y;
				st_nxt = pac_pkg::ST_ACC_Y;
			end
			pac_pkg::ST_ACC_Y: begin
				cmd.op = pac_pkg::DP_ACC_Y;
				if (closing_q) begin
					st_nxt = pac_pkg::ST_DIV_PREP;
				end else if (last_q) begin
					closing_nxt = 1'b1;
					st_nxt      = pac_pkg::ST_MUL_A;
				end else begin
					st_nxt = pac_pkg::ST_IDLE;
				end
			end
			pac_pkg::ST_DIV_PREP: begin
				cmd.op = pac_pkg::DP_DIV_PREP;
				st_nxt = stat.cross_zero ? pac_pkg::ST_RESULT : pac_pkg::ST_DIVX_GO;
			end
			pac_pkg::ST_DIVX_GO: begin
				cmd.div_start = 1'b1;
				st_nxt        = pac_pkg::ST_DIVX_WAIT;
			end
			pac_pkg::ST_DIVX_WAIT: begin
				if (stat.div_done) begin
					cmd.op = pac_pkg::DP_LATCH_QX;
					st_nxt = pac_pkg::ST_DIVY_GO;
				end
			end
			pac_pkg::ST_DIVY_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_sel_y = 1'b1;
				st_nxt        = pac_pkg::ST_DIVY_WAIT;
			end
			pac_pkg::ST_DIVY_WAIT: begin
				if (stat.div_done) begin
					cmd.op = pac_pkg::DP_LATCH_QY;
					st_nxt = pac_pkg::ST_RESULT;
				end
			end
			pac_pkg::ST_RESULT: begin
				if (stat.out_free) begin
					cmd.op      = pac_pkg::DP_EMIT;
					closing_nxt = 1'b0;
					last_nxt    = 1'b0;
					st_nxt      = pac_pkg::ST_IDLE;
				end
			end
			default: begin
				st_nxt = pac_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

>>> rtl/core/polygon_area_centroid_top.sv
// polygon_area_centroid_top: shoelace area and centroid of a polygon given
// vertex by vertex. Depends on pac_pkg, pac_ctrl, pac_datapath, pac_divider.
// Input channel: in_valid/in_stall with vertex_x, vertex_y (signed grid units)
// and last_vertex, which closes the polygon. Output channel: out_valid/
// out_stall with doubled_area, centroid_x, centroid_y, degenerate, overflow;
// one transaction per polygon, none for other vertices.
// The first vertex is only taken in; each further vertex up to the vertex
// limit then passes six steps through the single shared 17x33 multiplier
// and the accumulators while in_stall is high. The last vertex adds the
// closing edge in six more steps, a divisor step and two 61-bit divisions
// at one quotient bit per cycle.
// Zero-area and overflowed polygons skip the divisions.
// Reset clears all polygon state; the block then awaits a first vertex.
// A result waits in the output register while out_stall is high; the next
// polygon is taken meanwhile and only its own result waits for the register.
`timescale 1ns / 1ps

module polygon_area_centroid_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [pac_pkg::COORD_W-1:0]  vertex_x,
	input  logic signed [pac_pkg::COORD_W-1:0]  vertex_y,
	input  logic                                last_vertex,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [pac_pkg::AREA_W-1:0]   doubled_area,
	output logic signed [pac_pkg::COORD_W-1:0]  centroid_x,
	output logic signed [pac_pkg::COORD_W-1:0]  centroid_y,
	output logic                                degenerate,
	output logic                                overflow
);

	pac_pkg::cmd_t  cmd;
	pac_pkg::stat_t stat;

	// Sequencer
	pac_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.last_vertex (last_vertex),
		.stat        (stat),
		.cmd         (cmd)
	);

	// Arithmetic and result register
	pac_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.vertex_x     (vertex_x),
		.vertex_y     (vertex_y),
		.cmd          (cmd),
		.stat         (stat),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.doubled_area (doubled_area),
		.centroid_x   (centroid_x),
		.centroid_y   (centroid_y),
		.degenerate   (degenerate),
		.overflow     (overflow)
	);

endmodule

>>> tb/tb_polygon_area_centroid_top.sv
// tb_polygon_area_centroid_top: self-checking bench for the polygon area and
// centroid block. Depends on pac_pkg and polygon_area_centroid_top only.
// Directed polygons first, then random polygons with random idling on both sides.
`timescale 1ns / 1ps

module tb_polygon_area_centroid_top;

	localparam int CW             = pac_pkg::COORD_W;
	localparam int AW             = pac_pkg::AREA_W;
	localparam int MAXV           = pac_pkg::MAX_VERTICES;
	localparam int RANDOM_ITEMS   = 1800;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int DRAIN_CYCLES   = 200;

	// Vertex coordinate styles for the random part
	typedef enum int {
		CO_FULL,
		CO_TINY,
		CO_EXTREME,
		CO_MID
	} coord_style_t;

	typedef struct {
		logic signed [AW-1:0] area;
		logic signed [CW-1:0] cent_x;
		logic signed [CW-1:0] cent_y;
		logic                 degen;
		logic                 ovf;
	} polygon_result_t;

	// Shoelace predictor and store of results still owed by the block
	class pac_scoreboard;
		longint          first_x, first_y, prev_x, prev_y;
		longint          cross_sum, moment_x, moment_y;
		int              vertex_count;
		polygon_result_t results_due[$];
		int              mismatches;

		function new();
			mismatches = 0;
			clear_polygon();
		endfunction

		function void clear_polygon();
			first_x = 0;
			first_y = 0;
			prev_x = 0;
			prev_y = 0;
			cross_sum = 0;
			moment_x = 0;
			moment_y = 0;
			vertex_count = 0;
		endfunction

		function void add_edge(longint px, longint py, longint cx, longint cy);
			longint k;
			k = px * cy - cx * py;
			cross_sum += k;
			moment_x += (px + cx) * k;
			moment_y += (py + cy) * k;
		endfunction

		// Truncating division, then clamp to the signed coordinate range
		function logic signed [CW-1:0] centroid_axis(longint moment, longint divisor);
			longint q;
			longint hi;
			hi = (longint'(1) <<< (CW - 1)) - 1;
			q = moment / divisor;
			if (q > hi)
				q = hi;
			if (q < -hi - 1)
				q = -hi - 1;
			return q[CW-1:0];
		endfunction

		// Called for every accepted input transaction
		function void take_vertex(logic signed [CW-1:0] x, logic signed [CW-1:0] y,
				logic last);
			polygon_result_t r;
			if (vertex_count == 0) begin
				first_x = x;
				first_y = y;
				prev_x = x;
				prev_y = y;
				vertex_count = 1;
			end else if (vertex_count < MAXV) begin
				add_edge(prev_x, prev_y, x, y);
				prev_x = x;
				prev_y = y;
				vertex_count++;
			end else begin
				vertex_count = MAXV + 1;
			end
			if (!last)
				return;
			if (vertex_count > MAXV) begin
				r.area = '0;
				r.cent_x = '0;
				r.cent_y = '0;
				r.degen = 1'b0;
				r.ovf = 1'b1;
			end else begin
				// closing edge back to the first vertex
				add_edge(prev_x, prev_y, first_x, first_y);
				r.area = cross_sum[AW-1:0];
				r.ovf = 1'b0;
				if (cross_sum == 0) begin
					r.cent_x = '0;
					r.cent_y = '0;
					r.degen = 1'b1;
				end else begin
					r.cent_x = centroid_axis(moment_x, 3 * cross_sum);
					r.cent_y = centroid_axis(moment_y, 3 * cross_sum);
					r.degen = 1'b0;
				end
			end
			results_due.insert(results_due.size(), r);
			clear_polygon();
		endfunction

		// Called for every accepted output transaction
		function void check_result(polygon_result_t got);
			polygon_result_t want;
			if (results_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected result area=%0d cx=%0d cy=%0d deg=%0b ovf=%0b",
						$realtime, got.area, got.cent_x, got.cent_y, got.degen, got.ovf);
				return;
			end
			want = results_due.pop_front();
			if (got.area !== want.area || got.cent_x !== want.cent_x ||
					got.cent_y !== want.cent_y || got.degen !== want.degen ||
					got.ovf !== want.ovf) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("%0t: mismatch exp area=%0d cx=%0d cy=%0d deg=%0b ovf=%0b",
						$realtime, want.area, want.cent_x, want.cent_y, want.degen, want.ovf);
					$display("%0t:          act area=%0d cx=%0d cy=%0d deg=%0b ovf=%0b",
						$realtime, got.area, got.cent_x, got.cent_y, got.degen, got.ovf);
				end
			end
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic signed [CW-1:0] vertex_x = '0;
	logic signed [CW-1:0] vertex_y = '0;
	logic                 last_vertex = 1'b0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic signed [AW-1:0] doubled_area;
	logic signed [CW-1:0] centroid_x;
	logic signed [CW-1:0] centroid_y;
	logic                 degenerate;
	logic                 overflow;

	pac_scoreboard   sb = new();
	bit              in_idle_on = 1'b0;
	bit              out_idle_on = 1'b0;
	int              stall_left = 0;
	int              idle_cycles = 0;
	int              random_items = 0;
	polygon_result_t seen;

	polygon_area_centroid_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.vertex_x     (vertex_x),
		.vertex_y     (vertex_y),
		.last_vertex  (last_vertex),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.doubled_area (doubled_area),
		.centroid_x   (centroid_x),
		.centroid_y   (centroid_y),
		.degenerate   (degenerate),
		.overflow     (overflow)
	);

	always #5 clk = ~clk;

	// Gap length: mostly none or short, now and then long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic signed [CW-1:0] rand_coord(coord_style_t style);
		case (style)
			CO_TINY:    return $signed(CW'($urandom_range(0, 127))) - CW'(64);
			CO_EXTREME: begin
				case ($urandom_range(0, 4))
					0:       return {1'b1, {(CW-1){1'b0}}};
					1:       return {1'b0, {(CW-1){1'b1}}};
					2:       return {1'b1, {(CW-2){1'b0}}, 1'b1};
					3:       return {1'b0, {(CW-2){1'b1}}, 1'b0};
					default: return CW'($urandom);
				endcase
			end
			CO_MID:     return $signed(CW'($urandom_range(0, 4095))) - CW'(2048);
			default:    return CW'($urandom);
		endcase
	endfunction

	// Output side: random stall stretches while enabled
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if (arst_n && out_idle_on && $urandom_range(0, 2) == 0) begin
			stall_left = pick_gap();
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Monitor both channels and watch for a hang
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.take_vertex(vertex_x, vertex_y, last_vertex);
			if (out_valid && !out_stall) begin
				seen.area = doubled_area;
				seen.cent_x = centroid_x;
				seen.cent_y = centroid_y;
				seen.degen = degenerate;
				seen.ovf = overflow;
				sb.check_result(seen);
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("tb_polygon_area_centroid_top failed");
				$finish;
			end
		end
	end

	// One input transaction, with an optional gap ahead of it
	task automatic send_vertex(logic signed [CW-1:0] x, logic signed [CW-1:0] y,
			logic last);
		int gap;
		gap = in_idle_on ? pick_gap() : 0;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		vertex_x <= x;
		vertex_y <= y;
		last_vertex <= last;
		do
			@(posedge clk);
		while (in_stall);
	endtask

	task automatic send_random_polygon(int n, coord_style_t style);
		for (int i = 0; i < n; i++)
			send_vertex(rand_coord(style), rand_coord(style), i == n - 1);
	endtask

	// Points on one line: zero area
	task automatic send_collinear(int n);
		int bx, by, dx, dy, t;
		bx = $urandom_range(0, 2000) - 1000;
		by = $urandom_range(0, 2000) - 1000;
		dx = $urandom_range(0, 100) - 50;
		dy = $urandom_range(0, 100) - 50;
		for (int i = 0; i < n; i++) begin
			t = $urandom_range(0, 20) - 10;
			send_vertex(CW'(bx + t * dx), CW'(by + t * dy), i == n - 1);
		end
	endtask

	initial begin
		int poly_no;
		int n;
		int pick;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: lone vertex at the coordinate extremes
		send_vertex(16'sh7fff, 16'sh8000, 1'b1);
		// full-range square, counterclockwise then clockwise
		send_vertex(16'sh8000, 16'sh8000, 1'b0);
		send_vertex(16'sh7fff, 16'sh8000, 1'b0);
		send_vertex(16'sh7fff, 16'sh7fff, 1'b0);
		send_vertex(16'sh8000, 16'sh7fff, 1'b1);
		send_vertex(16'sh8000, 16'sh8000, 1'b0);
		send_vertex(16'sh8000, 16'sh7fff, 1'b0);
		send_vertex(16'sh7fff, 16'sh7fff, 1'b0);
		send_vertex(16'sh7fff, 16'sh8000, 1'b1);
		// collinear triangle and a two-vertex polygon
		send_vertex(0, 0, 1'b0);
		send_vertex(1, 1, 1'b0);
		send_vertex(2, 2, 1'b1);
		send_vertex(5, 7, 1'b0);
		send_vertex(-3, 2, 1'b1);
		// plain triangle, centroid (1, 1)
		send_vertex(0, 0, 1'b0);
		send_vertex(3, 0, 1'b0);
		send_vertex(0, 3, 1'b1);
		// crossed quadrilaterals whose centroid_y saturates high, then low
		send_vertex(0, 0, 1'b0);
		send_vertex(30000, 0, 1'b0);
		send_vertex(0, 30000, 1'b0);
		send_vertex(32000, 30000, 1'b1);
		send_vertex(0, 0, 1'b0);
		send_vertex(-30000, 0, 1'b0);
		send_vertex(0, -30000, 1'b0);
		send_vertex(-32000, -30000, 1'b1);

		// Random polygons; one very long one past the vertex limit
		poly_no = 0;
		while (random_items < RANDOM_ITEMS) begin
			in_idle_on = $urandom_range(0, 4) != 0;
			out_idle_on = $urandom_range(0, 4) != 0;
			poly_no++;
			if (poly_no == 15) begin
				n = MAXV + 1;
				send_random_polygon(n, CO_EXTREME);
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 70) begin
					n = $urandom_range(3, 8);
					send_random_polygon(n, coord_style_t'($urandom_range(0, 3)));
				end else if (pick < 80) begin
					n = $urandom_range(1, 2);
					send_random_polygon(n, coord_style_t'($urandom_range(0, 3)));
				end else if (pick < 90) begin
					n = $urandom_range(3, 6);
					send_collinear(n);
				end else begin
					n = $urandom_range(9, 40);
					send_random_polygon(n, coord_style_t'($urandom_range(0, 3)));
				end
			end
			random_items += n;
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.results_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.results_due.size() == 0)
			$display("tb_polygon_area_centroid_top passed");
		else
			$display("tb_polygon_area_centroid_top failed");
		$finish;
	end

endmodule
